@@ sv/kld_pkg.sv @@
package kld_pkg;

    localparam int HISTORY_DEPTH = 16;

    localparam int NOW_W    = 32;
    localparam int SAMPLE_W = 10;
    localparam int TH_W     = 10;
    localparam int MS_W     = 16;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    localparam logic [NOW_W-1:0] SAMPLE_PERIOD_MS = 32'd20;

    typedef logic [2:0] key_t;

    localparam key_t KEY_RIGHT  = 3'd0;
    localparam key_t KEY_UP     = 3'd1;
    localparam key_t KEY_DOWN   = 3'd2;
    localparam key_t KEY_LEFT   = 3'd3;
    localparam key_t KEY_SELECT = 3'd4;
    localparam key_t KEY_NONE   = 3'd5;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_NONE_TH   = 3'd0;
    localparam reg_idx_t REG_RIGHT_TH  = 3'd1;
    localparam reg_idx_t REG_UP_TH     = 3'd2;
    localparam reg_idx_t REG_DOWN_TH   = 3'd3;
    localparam reg_idx_t REG_LEFT_TH   = 3'd4;
    localparam reg_idx_t REG_INIT_REP  = 3'd5;
    localparam reg_idx_t REG_REP_STEP  = 3'd6;
    localparam reg_idx_t REG_MAX_DECR  = 3'd7;

    typedef struct packed {
        logic [TH_W-1:0] none_threshold;
        logic [TH_W-1:0] right_threshold;
        logic [TH_W-1:0] up_threshold;
        logic [TH_W-1:0] down_threshold;
        logic [TH_W-1:0] left_threshold;
        logic [MS_W-1:0] initial_repeat_ms;
        logic [MS_W-1:0] repeat_step_ms;
        logic [MS_W-1:0] max_decrease_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        none_threshold:    10'd1000,
        right_threshold:   10'd50,
        up_threshold:      10'd250,
        down_threshold:    10'd450,
        left_threshold:    10'd650,
        initial_repeat_ms: 16'd300,
        repeat_step_ms:    16'd20,
        max_decrease_ms:   16'd270
    };

endpackage

@@ sv/kld_regs.sv @@
module kld_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kld_pkg::PADDR_W-1:0]   paddr,
    input  logic [kld_pkg::PDATA_W-1:0]   pwdata,
    output logic [kld_pkg::PDATA_W-1:0]   prdata,
    output kld_pkg::cfg_t                 cfg
);

    kld_pkg::cfg_t     cfg_reg;
    kld_pkg::cfg_t     cfg_next;
    kld_pkg::reg_idx_t idx;
    logic              wr;

    assign idx = paddr[4:2];
    assign wr  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                kld_pkg::REG_NONE_TH:  cfg_next.none_threshold    = pwdata[kld_pkg::TH_W-1:0];
                kld_pkg::REG_RIGHT_TH: cfg_next.right_threshold   = pwdata[kld_pkg::TH_W-1:0];
                kld_pkg::REG_UP_TH:    cfg_next.up_threshold      = pwdata[kld_pkg::TH_W-1:0];
                kld_pkg::REG_DOWN_TH:  cfg_next.down_threshold    = pwdata[kld_pkg::TH_W-1:0];
                kld_pkg::REG_LEFT_TH:  cfg_next.left_threshold    = pwdata[kld_pkg::TH_W-1:0];
                kld_pkg::REG_INIT_REP: cfg_next.initial_repeat_ms = pwdata[kld_pkg::MS_W-1:0];
                kld_pkg::REG_REP_STEP: cfg_next.repeat_step_ms    = pwdata[kld_pkg::MS_W-1:0];
                kld_pkg::REG_MAX_DECR: cfg_next.max_decrease_ms   = pwdata[kld_pkg::MS_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            kld_pkg::REG_NONE_TH:  prdata = {22'd0, cfg_reg.none_threshold};
            kld_pkg::REG_RIGHT_TH: prdata = {22'd0, cfg_reg.right_threshold};
            kld_pkg::REG_UP_TH:    prdata = {22'd0, cfg_reg.up_threshold};
            kld_pkg::REG_DOWN_TH:  prdata = {22'd0, cfg_reg.down_threshold};
            kld_pkg::REG_LEFT_TH:  prdata = {22'd0, cfg_reg.left_threshold};
            kld_pkg::REG_INIT_REP: prdata = {16'd0, cfg_reg.initial_repeat_ms};
            kld_pkg::REG_REP_STEP: prdata = {16'd0, cfg_reg.repeat_step_ms};
            kld_pkg::REG_MAX_DECR: prdata = {16'd0, cfg_reg.max_decrease_ms};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= kld_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/kld_decode.sv @@
module kld_decode
(
    input  kld_pkg::cfg_t                 cfg,
    input  logic [kld_pkg::SAMPLE_W-1:0]  sample,
    output kld_pkg::key_t                 code
);

    // first matching test wins, thresholds are taken as written
    always_comb
    begin
        if (sample > cfg.none_threshold)
            code = kld_pkg::KEY_NONE;
        else if (sample < cfg.right_threshold)
            code = kld_pkg::KEY_RIGHT;
        else if (sample < cfg.up_threshold)
            code = kld_pkg::KEY_UP;
        else if (sample < cfg.down_threshold)
            code = kld_pkg::KEY_DOWN;
        else if (sample < cfg.left_threshold)
            code = kld_pkg::KEY_LEFT;
        else
            code = kld_pkg::KEY_SELECT;
    end

endmodule

@@ sv/kld_core.sv @@
module kld_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  kld_pkg::cfg_t                cfg,
    input  logic [kld_pkg::NOW_W-1:0]    now_ms,
    input  kld_pkg::key_t                code,
    output kld_pkg::key_t                key_code
);

    localparam int D = kld_pkg::HISTORY_DEPTH;

    kld_pkg::key_t                hist_reg [D];
    kld_pkg::key_t                hist_shift [D];
    logic [kld_pkg::NOW_W-1:0]    last_sample_reg;
    logic [kld_pkg::NOW_W-1:0]    last_report_reg;
    logic [kld_pkg::MS_W-1:0]     reduction_reg;
    logic [kld_pkg::MS_W-1:0]     reduction_next;

    logic [kld_pkg::NOW_W-1:0]    since_sample;
    logic [kld_pkg::NOW_W-1:0]    since_report;
    logic [kld_pkg::MS_W-1:0]     interval;
    logic [kld_pkg::MS_W:0]       red_sum;
    logic                         too_soon;
    logic                         all_equal;
    logic                         repeat_hit;
    logic                         press_hit;
    logic                         report;

    assign since_sample = now_ms - last_sample_reg;
    assign since_report = now_ms - last_report_reg;
    assign too_soon     = since_sample < kld_pkg::SAMPLE_PERIOD_MS;

    always_comb
    begin
        for (int i = 0; i < D - 1; i++)
            hist_shift[i] = hist_reg[i + 1];
        hist_shift[D - 1] = code;
    end

    always_comb
    begin
        all_equal = 1'b1;
        for (int i = 1; i < D; i++)
            if (hist_shift[i] != hist_shift[0])
                all_equal = 1'b0;
    end

    assign interval = (cfg.initial_repeat_ms > reduction_reg)
                    ? cfg.initial_repeat_ms - reduction_reg : '0;
    assign red_sum  = {1'b0, reduction_reg} + {1'b0, cfg.repeat_step_ms};

    assign repeat_hit = all_equal && (since_report > {16'd0, interval});
    // new press: two equal newest entries after a change
    assign press_hit  = (code == hist_shift[D - 2]) && (hist_shift[D - 2] != hist_shift[D - 3]);
    assign report     = !too_soon && (repeat_hit || press_hit);

    always_comb
    begin
        reduction_next = reduction_reg;
        if (repeat_hit)
            reduction_next = (red_sum > {1'b0, cfg.max_decrease_ms})
                           ? cfg.max_decrease_ms : red_sum[kld_pkg::MS_W-1:0];
        else if (press_hit)
            reduction_next = '0;
    end

    assign key_code = report ? code : kld_pkg::KEY_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
                hist_reg[i] <= kld_pkg::KEY_RIGHT;
            last_sample_reg <= '0;
            last_report_reg <= '0;
            reduction_reg   <= '0;
        end
        else if (en && !too_soon)
        begin
            for (int i = 0; i < D; i++)
                hist_reg[i] <= hist_shift[i];
            last_sample_reg <= now_ms;
            if (repeat_hit || press_hit)
            begin
                last_report_reg <= now_ms;
                reduction_reg   <= reduction_next;
            end
        end
    end

endmodule

@@ sv/keypad_ladder_debounce_autorepeat.sv @@
// Keypad ladder reader: one poll per request on the s_ side, one key code per
// poll on the m_ side, in order. A poll is taken every clock when the output
// is drained. The sample is decoded into the input register when the poll is
// accepted, then the single history/repeat-timer update writes the output
// register when the input register advances. An unread result holds the input
// register, so a new poll is then taken only while that register is empty.
// Thresholds and repeat timing live in eight APB registers at byte addresses
// 0x00..0x1C, written while idle.
module keypad_ladder_debounce_autorepeat
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kld_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] now_ms, [41:32] adc_sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kld_pkg::M_TDATA_W-1:0]   m_tdata,   // [2:0] key_code
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kld_pkg::PADDR_W-1:0]     paddr,
    input  logic [kld_pkg::PDATA_W-1:0]     pwdata,
    output logic [kld_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    kld_pkg::cfg_t                  cfg;
    kld_pkg::key_t                  dec_code;
    kld_pkg::key_t                  core_key;

    logic                           in_valid_reg;
    logic [kld_pkg::NOW_W-1:0]      in_now_reg;
    kld_pkg::key_t                  in_code_reg;
    logic                           out_valid_reg;
    kld_pkg::key_t                  out_code_reg;

    logic                           accept;
    logic                           advance;

    assign pready = 1'b1;

    kld_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    kld_decode u_decode
    (
        .cfg    (cfg),
        .sample (s_tdata[41:32]),
        .code   (dec_code)
    );

    kld_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .cfg      (cfg),
        .now_ms   (in_now_reg),
        .code     (in_code_reg),
        .key_code (core_key)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_now_reg  <= s_tdata[31:0];
            in_code_reg <= dec_code;
        end
        if (advance)
            out_code_reg <= core_key;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_code_reg};

endmodule

@@ sv/kld_checker.sv @@
module kld_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [31:0] prdata,
    input  logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:3] == 5'd0) && (m_tdata[2:0] <= 3'd5))
        else $error("key code out of range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("poll refused with empty output");

    a_apb: assert property (@(posedge clk) disable iff (!rst_n)
        pready && (prdata[31:16] == 16'd0))
        else $error("register port misbehaves");

endmodule

bind keypad_ladder_debounce_autorepeat kld_checker u_kld_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .prdata   (prdata),
    .pready   (pready)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import kld_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [31:0] now_ms, [41:32] adc_sample
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [2:0] key_code
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    keypad_ladder_debounce_autorepeat dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // keypad state as the block should hold it
    cfg_t        cfg_model;
    key_t        key_hist [HISTORY_DEPTH];
    logic [31:0] last_poll_ms;
    logic [31:0] last_report_ms;
    logic [31:0] rep_reduction;

    key_t        expected_keys [$];
    logic [31:0] ms_now;
    bit          send_gaps_on;
    bit          stall_on;
    int          polls_sent;
    int          keys_checked;
    int          key_reports;
    int          settings_applied;
    int          mismatches;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic key_t decode_level(logic [9:0] sample);
        if (sample > cfg_model.none_threshold) return KEY_NONE;
        if (sample < cfg_model.right_threshold) return KEY_RIGHT;
        if (sample < cfg_model.up_threshold) return KEY_UP;
        if (sample < cfg_model.down_threshold) return KEY_DOWN;
        if (sample < cfg_model.left_threshold) return KEY_LEFT;
        return KEY_SELECT;
    endfunction

    // one poll: debounce, history shift, long-press repeat or new press
    function automatic key_t predict_key(logic [31:0] now, logic [9:0] sample);
        key_t        code;
        logic [31:0] interval;
        logic [31:0] since_report;
        logic [31:0] grown;
        bit          all_same;
        if (now - last_poll_ms < SAMPLE_PERIOD_MS) return KEY_NONE;
        last_poll_ms = now;
        code = decode_level(sample);
        for (int i = 1; i < HISTORY_DEPTH; i++) key_hist[i-1] = key_hist[i];
        key_hist[HISTORY_DEPTH-1] = code;
        all_same = 1'b1;
        for (int i = 1; i < HISTORY_DEPTH; i++)
            if (key_hist[i] != key_hist[0]) all_same = 1'b0;
        interval = (32'(cfg_model.initial_repeat_ms) > rep_reduction)
                 ? 32'(cfg_model.initial_repeat_ms) - rep_reduction : 32'd0;
        since_report = now - last_report_ms;
        if (all_same && since_report > interval)
        begin
            grown = rep_reduction + 32'(cfg_model.repeat_step_ms);
            last_report_ms = now;
            rep_reduction = (grown > 32'(cfg_model.max_decrease_ms))
                          ? 32'(cfg_model.max_decrease_ms) : grown;
            return code;
        end
        if (code == key_hist[HISTORY_DEPTH-2] &&
            key_hist[HISTORY_DEPTH-2] != key_hist[HISTORY_DEPTH-3])
        begin
            last_report_ms = now;
            rep_reduction = 32'd0;
            return code;
        end
        return KEY_NONE;
    endfunction

    // ladder level that decodes to the wanted key under the current thresholds
    function automatic logic [9:0] level_for(key_t k);
        logic [9:0] s;
        s = '0;
        for (int t = 0; t < 64; t++)
        begin
            s = 10'($urandom_range(0, 1023));
            if (decode_level(s) == k) return s;
        end
        return s;
    endfunction

    always @(posedge clk)
    begin : check_keys
        key_t want_key;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_keys.size() == 0)
            begin
                $error("key_code: no request pending, got %0d", m_tdata[2:0]);
                mismatches++;
            end
            else
            begin
                want_key = expected_keys.pop_front();
                keys_checked++;
                if (m_tdata[2:0] !== want_key)
                begin
                    $error("key_code: expected %0d, got %0d", want_key, m_tdata[2:0]);
                    mismatches++;
                end
                if (m_tdata[M_TDATA_W-1:3] !== '0)
                begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[M_TDATA_W-1:3]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : ready_driver
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(0, 6);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_poll(logic [31:0] now, logic [9:0] sample);
        key_t k;
        if (send_gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, sample, now};
        do @(posedge clk); while (!s_tready);
        k = predict_key(now, sample);
        if (k != KEY_NONE) key_reports++;
        expected_keys.push_back(k);
        polls_sent++;
    endtask

    task automatic poll_after(int unsigned dt, logic [9:0] sample);
        ms_now = ms_now + dt;
        send_poll(ms_now, sample);
    endtask

    task automatic wait_results_done;
        s_tvalid <= 1'b0;
        while (expected_keys.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_NONE_TH:  cfg_model.none_threshold    = value[9:0];
            REG_RIGHT_TH: cfg_model.right_threshold   = value[9:0];
            REG_UP_TH:    cfg_model.up_threshold      = value[9:0];
            REG_DOWN_TH:  cfg_model.down_threshold    = value[9:0];
            REG_LEFT_TH:  cfg_model.left_threshold    = value[9:0];
            REG_INIT_REP: cfg_model.initial_repeat_ms = value;
            REG_REP_STEP: cfg_model.repeat_step_ms    = value;
            REG_MAX_DECR: cfg_model.max_decrease_ms   = value;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(cfg_t c);
        wait_results_done();
        write_reg(REG_NONE_TH,  16'(c.none_threshold));
        write_reg(REG_RIGHT_TH, 16'(c.right_threshold));
        write_reg(REG_UP_TH,    16'(c.up_threshold));
        write_reg(REG_DOWN_TH,  16'(c.down_threshold));
        write_reg(REG_LEFT_TH,  16'(c.left_threshold));
        write_reg(REG_INIT_REP, c.initial_repeat_ms);
        write_reg(REG_REP_STEP, c.repeat_step_ms);
        write_reg(REG_MAX_DECR, c.max_decrease_ms);
        settings_applied++;
    endtask

    // presses of random keys: mostly taps, some held long enough to repeat,
    // with bounce timing and stray levels mixed in
    task automatic run_presses(int n_items);
        int   done;
        int   hold;
        key_t k;
        done = 0;
        while (done < n_items)
        begin
            k = key_t'($urandom_range(0, 5));
            hold = ($urandom_range(0, 2) == 0) ? $urandom_range(16, 60)
                                                : $urandom_range(1, 6);
            for (int i = 0; i < hold && done < n_items; i++)
            begin
                poll_after(($urandom_range(0, 9) == 0) ? $urandom_range(0, 19)
                                                       : $urandom_range(20, 45),
                           ($urandom_range(0, 11) == 0) ? 10'($urandom_range(0, 1023))
                                                        : level_for(k));
                done++;
            end
        end
    endtask

    task automatic test_directed;
        poll_after(0, 10'd0);        // inside the sample period after reset
        poll_after(400, 10'd0);      // reset history is all right: long press
        poll_after(5, 10'd0);        // too soon
        poll_after(25, 10'd1023);
        poll_after(25, 10'd1001);
        poll_after(25, 10'd1000);
        poll_after(25, 10'd1000);
        poll_after(25, 10'd49);
        poll_after(25, 10'd50);
        poll_after(25, 10'd50);
        poll_after(25, 10'd249);
        poll_after(25, 10'd250);
        poll_after(25, 10'd250);
        poll_after(25, 10'd449);
        poll_after(25, 10'd450);
        poll_after(25, 10'd450);
        poll_after(25, 10'd649);
        poll_after(25, 10'd650);
        poll_after(25, 10'd650);
        poll_after(19, 10'd0);
        // timer wrap across zero
        ms_now = 32'hFFFF_FFF0;
        poll_after(0, 10'd300);
        poll_after(25, 10'd300);
        poll_after(20, 10'd300);
        wait_results_done();
    endtask

    task automatic test_settings;
        cfg_t c;
        c = CFG_RESET;
        apply_settings(c);
        run_presses(100);

        // quick acceleration to the floor
        c.initial_repeat_ms = 16'd100;
        c.repeat_step_ms    = 16'd30;
        c.max_decrease_ms   = 16'd90;
        apply_settings(c);
        run_presses(100);

        // shrinkage past the interval: any elapsed time repeats
        c.initial_repeat_ms = 16'd40;
        c.repeat_step_ms    = 16'd50;
        c.max_decrease_ms   = 16'hFFFF;
        apply_settings(c);
        run_presses(100);

        c = '0;
        c.initial_repeat_ms = 16'd1;
        apply_settings(c);
        run_presses(100);

        c.none_threshold    = 10'd1023;
        c.right_threshold   = 10'd1023;
        c.up_threshold      = 10'd1023;
        c.down_threshold    = 10'd1023;
        c.left_threshold    = 10'd1023;
        c.initial_repeat_ms = 16'hFFFF;
        c.repeat_step_ms    = 16'hFFFF;
        c.max_decrease_ms   = 16'hFFFF;
        apply_settings(c);
        run_presses(100);

        // thresholds in any order
        c.none_threshold    = 10'($urandom_range(0, 1023));
        c.right_threshold   = 10'($urandom_range(0, 1023));
        c.up_threshold      = 10'($urandom_range(0, 1023));
        c.down_threshold    = 10'($urandom_range(0, 1023));
        c.left_threshold    = 10'($urandom_range(0, 1023));
        c.initial_repeat_ms = 16'($urandom_range(1, 200));
        c.repeat_step_ms    = 16'($urandom_range(0, 60));
        c.max_decrease_ms   = 16'($urandom_range(0, 300));
        apply_settings(c);
        run_presses(100);
    endtask

    // cap lowered under the running reduction in the middle of a long press
    task automatic test_cap_lowered;
        cfg_t c;
        c = CFG_RESET;
        c.initial_repeat_ms = 16'd60;
        c.repeat_step_ms    = 16'd20;
        c.max_decrease_ms   = 16'd200;
        apply_settings(c);
        for (int i = 0; i < 40; i++) poll_after(20, 10'd300);
        wait_results_done();
        write_reg(REG_MAX_DECR, 16'd5);
        for (int i = 0; i < 20; i++) poll_after($urandom_range(20, 30), 10'd300);
        wait_results_done();
    endtask

    // arbitrary timestamps and levels
    task automatic test_noise(int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                ms_now = $urandom;
            else
                ms_now = ms_now + $urandom_range(0, 40);
            send_poll(ms_now, 10'($urandom_range(0, 1023)));
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cfg_model = CFG_RESET;
        foreach (key_hist[i]) key_hist[i] = KEY_RIGHT;
        last_poll_ms   = '0;
        last_report_ms = '0;
        rep_reduction  = '0;
        ms_now         = '0;
        send_gaps_on   = 1'b1;
        stall_on       = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_settings();
        test_cap_lowered();
        test_noise(100);
        send_gaps_on = 1'b0;
        stall_on     = 1'b0;
        apply_settings(CFG_RESET);
        run_presses(150);
        wait_results_done();
        repeat (10) @(posedge clk);

        $display("%0d polls over %0d register settings, %0d key codes checked",
                 polls_sent, settings_applied, keys_checked);
        $display("%0d key reports (new presses and repeats), %0d mismatches",
                 key_reports, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
